### hdl/utf8p_pkg.sv
package utf8p_pkg;

    // Default width of the line and column counters.
    localparam int unsigned POSITION_BITS_DEF = 16;

    localparam int unsigned CP_BITS  = 21;
    localparam int unsigned OUT_BITS = 16;
    localparam int unsigned BYTE_BITS = 8;

    localparam logic [CP_BITS-1:0]   BOM_VALUE    = 21'h00FEFF;
    localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;

    // Kind of a result item.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_LEAD = 2'd1,
        ERR_CONT = 2'd2
    } t_err_kind;

    // Position update requested by the decoder for one byte.
    typedef struct packed {
        logic advance_col;
        logic new_line;
    } t_pos_cmd;

    // One decoded result before it is joined with the position.
    typedef struct packed {
        logic               emit;
        logic [CP_BITS-1:0] code_point;
        t_err_kind          kind;
        logic               column_zero;
    } t_char;

endpackage

### hdl/utf8_decoder_with_position_core.sv
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_stall       | i_byte_in
// result    | out       | o_out_valid / i_out_stall     | o_code_point, o_line_number,
//           |           |                               | o_column_number, o_error_kind
// config    | in        | i_cfg_valid / o_cfg_ready     | i_cfg_data
//
// One item is accepted per cycle while the result side keeps up; a result is
// offered once its byte has passed through the input register, one decode
// step and the result register.
// Synchronous active-low reset clears the decoder, sets line and column to 1
// and re-arms byte order mark skipping. A result-side stall holds the result
// register; the empty input register takes one more item, then o_in_stall rises.
module utf8_decoder_with_position_core #(
    parameter int unsigned POSITION_BITS = utf8p_pkg::POSITION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Byte input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [utf8p_pkg::BYTE_BITS-1:0]    i_byte_in,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [utf8p_pkg::CP_BITS-1:0]      o_code_point,
    output logic [utf8p_pkg::OUT_BITS-1:0]     o_line_number,
    output logic [utf8p_pkg::OUT_BITS-1:0]     o_column_number,
    output logic [1:0]                         o_error_kind,
    // Configuration write channel: skip_byte_order_mark.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);

    // Input register stage.
    logic                              r_in_valid;
    logic [utf8p_pkg::BYTE_BITS-1:0]   r_byte;

    // Result register stage.
    logic                              r_out_valid;
    logic [utf8p_pkg::CP_BITS-1:0]     r_code_point;
    logic [utf8p_pkg::OUT_BITS-1:0]    r_line_number;
    logic [utf8p_pkg::OUT_BITS-1:0]    r_column_number;
    utf8p_pkg::t_err_kind              r_error_kind;

    // Configuration register.
    logic                              r_skip_bom;

    logic                              out_ready;
    logic                              in_ready;
    logic                              step;
    utf8p_pkg::t_char                  dec_char;
    utf8p_pkg::t_pos_cmd               pos_cmd;
    logic [POSITION_BITS-1:0]          line_cnt;
    logic [POSITION_BITS-1:0]          col_cnt;
    logic [POSITION_BITS+utf8p_pkg::OUT_BITS-1:0] line_ext;
    logic [POSITION_BITS+utf8p_pkg::OUT_BITS-1:0] col_ext;

    // The result register frees up when it is empty or being taken; the
    // input register frees up when empty or when its item moves on.
    assign out_ready = !r_out_valid || !i_out_stall;
    assign step      = r_in_valid && out_ready;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_bom <= 1'b1;
        end else if (i_cfg_valid) begin
            r_skip_bom <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_byte <= i_byte_in;
        end
    end

    utf8p_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_byte),
        .i_skip_bom (r_skip_bom),
        .o_char     (dec_char),
        .o_cmd      (pos_cmd)
    );

    utf8p_pos #(
        .POSITION_BITS (POSITION_BITS)
    ) u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cmd    (pos_cmd),
        .o_line   (line_cnt),
        .o_column (col_cnt)
    );

    // The output fields carry the low bits of the counters, zero-padded
    // when the counters are narrower than the ports.
    assign line_ext = {{utf8p_pkg::OUT_BITS{1'b0}}, line_cnt};
    assign col_ext  = {{utf8p_pkg::OUT_BITS{1'b0}}, col_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= step && dec_char.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && dec_char.emit) begin
            r_code_point    <= dec_char.code_point;
            r_line_number   <= line_ext[utf8p_pkg::OUT_BITS-1:0];
            r_column_number <= dec_char.column_zero ? '0
                                                    : col_ext[utf8p_pkg::OUT_BITS-1:0];
            r_error_kind    <= dec_char.kind;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_code_point;
    assign o_line_number   = r_line_number;
    assign o_column_number = r_column_number;
    assign o_error_kind    = r_error_kind;

endmodule

### hdl/utf8p_pos.sv
module utf8p_pos #(
    parameter int unsigned POSITION_BITS = utf8p_pkg::POSITION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  utf8p_pkg::t_pos_cmd      i_cmd,
    output logic [POSITION_BITS-1:0] o_line,
    output logic [POSITION_BITS-1:0] o_column
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] r_line;
    logic [POSITION_BITS-1:0] r_column;
    logic [POSITION_BITS-1:0] n_line;
    logic [POSITION_BITS-1:0] n_column;

    always_comb begin
        n_line   = r_line;
        n_column = r_column;
        if (i_step) begin
            if (i_cmd.new_line) begin
                n_line   = (r_line == POS_MAX) ? POS_MAX : r_line + POS_ONE;
                n_column = POS_ONE;
            end else if (i_cmd.advance_col) begin
                n_column = (r_column == POS_MAX) ? POS_MAX : r_column + POS_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= POS_ONE;
            r_column <= POS_ONE;
        end else begin
            r_line   <= n_line;
            r_column <= n_column;
        end
    end

    assign o_line   = r_line;
    assign o_column = r_column;

endmodule

### hdl/utf8p_decode.sv
module utf8p_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [utf8p_pkg::BYTE_BITS-1:0]   i_byte,
    input  logic                              i_skip_bom,
    output utf8p_pkg::t_char                  o_char,
    output utf8p_pkg::t_pos_cmd               o_cmd
);

    logic [1:0]                     r_remaining;
    logic [utf8p_pkg::CP_BITS-1:0]  r_partial;
    logic                           r_cont_bad;
    logic                           r_at_start;

    logic [1:0]                     n_remaining;
    logic [utf8p_pkg::CP_BITS-1:0]  n_partial;
    logic                           n_cont_bad;
    logic                           n_at_start;

    logic                           finish;
    logic                           single_byte;
    logic [utf8p_pkg::CP_BITS-1:0]  fin_cp;
    utf8p_pkg::t_err_kind           fin_kind;
    logic                           swallow;

    always_comb begin
        n_remaining = r_remaining;
        n_partial   = r_partial;
        n_cont_bad  = r_cont_bad;
        n_at_start  = r_at_start;
        finish      = 1'b0;
        single_byte = 1'b0;
        fin_cp      = '0;
        fin_kind    = utf8p_pkg::ERR_NONE;
        swallow     = 1'b0;
        o_char      = '0;
        o_cmd       = '0;

        if (r_remaining != 2'd0) begin
            // Inside a sequence every byte is taken as a continuation byte.
            n_cont_bad  = r_cont_bad | (i_byte[7:6] != 2'b10);
            n_partial   = {r_partial[utf8p_pkg::CP_BITS-7:0], i_byte[5:0]};
            n_remaining = r_remaining - 2'd1;
            if (n_remaining == 2'd0) begin
                finish   = 1'b1;
                fin_cp   = n_partial;
                fin_kind = n_cont_bad ? utf8p_pkg::ERR_CONT : utf8p_pkg::ERR_NONE;
            end
        end else if (!i_byte[7]) begin
            finish      = 1'b1;
            single_byte = 1'b1;
            fin_cp      = {13'd0, i_byte};
        end else begin
            n_cont_bad = 1'b0;
            priority if (i_byte[7:5] == 3'b110) begin
                n_partial   = {16'd0, i_byte[4:0]};
                n_remaining = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_partial   = {17'd0, i_byte[3:0]};
                n_remaining = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_partial   = {18'd0, i_byte[2:0]};
                n_remaining = 2'd3;
            end else begin
                // Bad lead byte: error result, position unchanged.
                n_partial          = '0;
                n_at_start         = 1'b0;
                o_char.emit        = 1'b1;
                o_char.code_point  = '0;
                o_char.kind        = utf8p_pkg::ERR_LEAD;
                o_char.column_zero = 1'b1;
            end
        end

        if (finish) begin
            n_at_start = 1'b0;
            swallow = r_at_start && i_skip_bom && (fin_kind == utf8p_pkg::ERR_NONE)
                      && (fin_cp == utf8p_pkg::BOM_VALUE);
            if (!swallow) begin
                o_char.emit        = 1'b1;
                o_char.code_point  = fin_cp;
                o_char.kind        = fin_kind;
                o_char.column_zero = 1'b0;
                if (single_byte && (i_byte == utf8p_pkg::NEWLINE_BYTE)) begin
                    o_cmd.new_line = 1'b1;
                end else begin
                    o_cmd.advance_col = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 2'd0;
            r_partial   <= '0;
            r_cont_bad  <= 1'b0;
            r_at_start  <= 1'b1;
        end else if (i_step) begin
            r_remaining <= n_remaining;
            r_partial   <= n_partial;
            r_cont_bad  <= n_cont_bad;
            r_at_start  <= n_at_start;
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned POS_BITS     = utf8p_pkg::POSITION_BITS_DEF;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          QUIET_LIMIT  = 2000;

    // One decoded character as it leaves the block.
    typedef struct packed {
        logic [utf8p_pkg::CP_BITS-1:0]  cp;
        logic [utf8p_pkg::OUT_BITS-1:0] line;
        logic [utf8p_pkg::OUT_BITS-1:0] col;
        utf8p_pkg::t_err_kind           kind;
    } t_decoded;

    localparam t_decoded NO_CHECK = '{21'd0, 16'd0, 16'd0, utf8p_pkg::ERR_NONE};

    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_decoded   want;
    } t_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic [7:0]                     i_byte_in   = 8'd0;
    logic                           i_out_stall = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           i_cfg_data  = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [utf8p_pkg::CP_BITS-1:0]  o_code_point;
    logic [utf8p_pkg::OUT_BITS-1:0] o_line_number;
    logic [utf8p_pkg::OUT_BITS-1:0] o_column_number;
    logic [1:0]                     o_error_kind;
    logic                           o_cfg_ready;

    // Decoder state as the predictor sees it.
    logic [1:0]                    cont_left    = 2'd0;
    logic [utf8p_pkg::CP_BITS-1:0] partial_cp   = '0;
    logic                          cont_flagged = 1'b0;
    logic [POS_BITS-1:0]           cur_line     = POS_BITS'(1);
    logic [POS_BITS-1:0]           cur_col      = POS_BITS'(1);
    logic                          fresh_stream = 1'b1;
    logic                          skip_bom     = 1'b1;

    t_decoded pending_chars[$];
    t_decoded seen, wanted;
    int       bad_results   = 0;
    int       quiet_cycles  = 0;
    int       bytes_fed     = 0;
    int       feed_gap_pct  = 32;
    int       drain_gap_pct = 51;
    int       hold_asks     = 0;

    // Opening stream: a byte order mark to be dropped, the ASCII extremes, a newline,
    // bad lead bytes, sequences of every length, a broken continuation that carries a
    // newline byte, a clean two-byte newline and a byte order mark that is no longer first.
    t_row directed_rows [26] = '{
        '{8'hEF, 1'b0, NO_CHECK},
        '{8'hBB, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, NO_CHECK},
        '{8'h41, 1'b1, '{21'h41, 16'd1, 16'd1, utf8p_pkg::ERR_NONE}},
        '{8'h00, 1'b1, '{21'h00, 16'd1, 16'd2, utf8p_pkg::ERR_NONE}},
        '{8'h7F, 1'b1, '{21'h7F, 16'd1, 16'd3, utf8p_pkg::ERR_NONE}},
        '{8'h0A, 1'b1, '{21'h0A, 16'd1, 16'd4, utf8p_pkg::ERR_NONE}},
        '{8'h80, 1'b1, '{21'h00, 16'd2, 16'd0, utf8p_pkg::ERR_LEAD}},
        '{8'hFF, 1'b1, '{21'h00, 16'd2, 16'd0, utf8p_pkg::ERR_LEAD}},
        '{8'hF8, 1'b1, '{21'h00, 16'd2, 16'd0, utf8p_pkg::ERR_LEAD}},
        '{8'hC2, 1'b0, NO_CHECK},
        '{8'hA9, 1'b0, NO_CHECK},
        '{8'hE2, 1'b0, NO_CHECK},
        '{8'h82, 1'b0, NO_CHECK},
        '{8'hAC, 1'b0, NO_CHECK},
        '{8'hF7, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, NO_CHECK},
        '{8'hC0, 1'b0, NO_CHECK},
        '{8'h0A, 1'b0, NO_CHECK},
        '{8'hC0, 1'b0, NO_CHECK},
        '{8'h8A, 1'b0, NO_CHECK},
        '{8'hEF, 1'b0, NO_CHECK},
        '{8'hBB, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, NO_CHECK}
    };

    utf8_decoder_with_position_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_in       (i_byte_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_point    (o_code_point),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_error_kind    (o_error_kind),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [POS_BITS-1:0] pos_step(input logic [POS_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // A character is complete: emit it with its position unless it is a leading mark to be skipped.
    function automatic bit close_char(input logic [utf8p_pkg::CP_BITS-1:0] cp,
                                      input utf8p_pkg::t_err_kind kind,
                                      input bit single, output t_decoded r);
        bit first;
        first        = fresh_stream;
        fresh_stream = 1'b0;
        r            = NO_CHECK;
        if (first && skip_bom && kind == utf8p_pkg::ERR_NONE
                && cp == utf8p_pkg::BOM_VALUE) begin
            return 1'b0;
        end
        r = '{cp, cur_line[utf8p_pkg::OUT_BITS-1:0], cur_col[utf8p_pkg::OUT_BITS-1:0], kind};
        if (single && cp == {13'd0, utf8p_pkg::NEWLINE_BYTE}) begin
            cur_line = pos_step(cur_line);
            cur_col  = POS_BITS'(1);
        end else begin
            cur_col = pos_step(cur_col);
        end
        return 1'b1;
    endfunction

    function automatic bit predict_byte(input logic [7:0] b, output t_decoded r);
        r = NO_CHECK;
        if (cont_left != 2'd0) begin
            // Inside a sequence every byte is taken as a continuation.
            if (b[7:6] != 2'b10) begin
                cont_flagged = 1'b1;
            end
            partial_cp = {partial_cp[utf8p_pkg::CP_BITS-7:0], b[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left != 2'd0) begin
                return 1'b0;
            end
            return close_char(partial_cp,
                              cont_flagged ? utf8p_pkg::ERR_CONT : utf8p_pkg::ERR_NONE,
                              1'b0, r);
        end
        if (b[7] == 1'b0) begin
            return close_char({13'd0, b}, utf8p_pkg::ERR_NONE, 1'b1, r);
        end
        cont_flagged = 1'b0;
        if (b[7:5] == 3'b110) begin
            partial_cp = {16'd0, b[4:0]};
            cont_left  = 2'd1;
            return 1'b0;
        end
        if (b[7:4] == 4'b1110) begin
            partial_cp = {17'd0, b[3:0]};
            cont_left  = 2'd2;
            return 1'b0;
        end
        if (b[7:3] == 5'b11110) begin
            partial_cp = {18'd0, b[2:0]};
            cont_left  = 2'd3;
            return 1'b0;
        end
        partial_cp   = '0;
        fresh_stream = 1'b0;
        r = '{21'd0, cur_line[utf8p_pkg::OUT_BITS-1:0], 16'd0, utf8p_pkg::ERR_LEAD};
        return 1'b1;
    endfunction

    // Offers one byte, holds it until taken, then records what it should produce.
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_decoded fixed = NO_CHECK);
        t_decoded r;
        while ($urandom_range(99) < feed_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_byte(b, r)) begin
            pending_chars.push_back(typed ? fixed : r);
        end
        bytes_fed++;
    endtask

    // Stops feeding until every awaited character is out and the pipeline is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_skip_bom(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        skip_bom = v;
    endtask

    // Mostly well-formed characters with random content, plus broken sequences,
    // stray continuation bytes, invalid lead bytes and raw noise.
    task automatic feed_random(input int count);
        int         stop, pick, len, bad_at, k;
        logic [7:0] lead;
        stop = bytes_fed + count;
        while (bytes_fed < stop) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                if ($urandom_range(9) == 0) begin
                    push_byte(utf8p_pkg::NEWLINE_BYTE);
                end else begin
                    push_byte(8'($urandom_range(8'h7F, 8'h00)));
                end
            end else if (pick < 92) begin
                len    = (pick < 50) ? 2 : (pick < 65) ? 3 : (pick < 78) ? 4
                       : $urandom_range(4, 2);
                bad_at = (pick >= 78) ? $urandom_range(len - 1, 1) : 0;
                unique case (len)
                    2: lead = 8'($urandom_range(8'hDF, 8'hC0));
                    3: lead = 8'($urandom_range(8'hEF, 8'hE0));
                    default: lead = 8'($urandom_range(8'hF7, 8'hF0));
                endcase
                push_byte(lead);
                for (k = 1; k < len; k++) begin
                    if (k == bad_at) begin
                        push_byte(8'($urandom_range(255)));
                    end else begin
                        push_byte(8'($urandom_range(8'hBF, 8'h80)));
                    end
                end
            end else if (pick < 97) begin
                if ($urandom_range(1) == 0) begin
                    push_byte(8'($urandom_range(8'hBF, 8'h80)));
                end else begin
                    push_byte(8'($urandom_range(8'hFF, 8'hF8)));
                end
            end else begin
                push_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Result side: random stalls, and a long hold-off whenever one is asked for.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_seen != hold_asks) begin
                hold_seen   = hold_asks;
                hold_left   = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < drain_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_code_point, o_line_number, o_column_number,
                     utf8p_pkg::t_err_kind'(o_error_kind)};
            if (pending_chars.size() == 0) begin
                if (bad_results < 10) begin
                    $display("unexpected result: cp=%h line=%0d col=%0d kind=%0d",
                             seen.cp, seen.line, seen.col, seen.kind);
                end
                bad_results++;
            end else begin
                wanted = pending_chars.pop_front();
                if (seen.cp !== wanted.cp || seen.line !== wanted.line
                        || seen.col !== wanted.col || seen.kind !== wanted.kind) begin
                    if (bad_results < 10) begin
                        $display("mismatch: expected cp=%h line=%0d col=%0d kind=%0d",
                                 wanted.cp, wanted.line, wanted.col, wanted.kind);
                        $display("          got      cp=%h line=%0d col=%0d kind=%0d",
                                 seen.cp, seen.line, seen.col, seen.kind);
                    end
                    bad_results++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_skip_bom(1'b0);
        write_skip_bom(1'b1);
        foreach (directed_rows[n]) begin
            push_byte(directed_rows[n].b, directed_rows[n].typed, directed_rows[n].want);
        end

        // The receiver is the slower side here; midway the receiver holds off so that
        // the block fills and stalls its input.
        settle();
        write_skip_bom(1'b0);
        feed_random(RANDOM_ITEMS / 6);
        hold_asks++;
        feed_random(RANDOM_ITEMS / 6);

        settle();
        feed_gap_pct  = 51;
        drain_gap_pct = 32;
        write_skip_bom(1'b1);
        feed_random(RANDOM_ITEMS / 6);
        settle();
        feed_random(RANDOM_ITEMS / 6);

        settle();
        feed_gap_pct  = 0;
        drain_gap_pct = 0;
        write_skip_bom(1'b0);
        feed_random(RANDOM_ITEMS / 3);

        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && pending_chars.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### utf8_decoder_with_position_core.f
hdl/utf8p_pkg.sv
hdl/utf8p_pos.sv
hdl/utf8p_decode.sv
hdl/utf8_decoder_with_position_core.sv
bench/testbench.sv
